// ===== rtl/ramr_pkg.sv =====
// Package: shared types, constants and codes for the rational arithmetic unit.
package ramr_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int MAG_W = 64;

  localparam logic [1:0] OP_NORM = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;

  // Raw fraction handed from the front end to the reduction engine.
  typedef struct packed {
    logic             zero_den;
    logic             num_neg;
    logic [MAG_W-1:0] num_mag;
    logic             den_neg;
    logic [MAG_W-1:0] den_mag;
  } raw_frac_t;

endpackage

// ===== rtl/ramr_if.sv =====
// Interfaces: request and result channels with valid/ready handshake.
interface ramr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ramr_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic        status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface

interface ramr_raw_if;
  import ramr_pkg::*;
  logic      valid;
  logic      ready;
  raw_frac_t frac;
  modport source (output valid, frac, input ready);
  modport sink (input valid, frac, output ready);
endinterface

// ===== rtl/ramr_front.sv =====
// Front end: take operands, cross-multiply in states M1, M2 and M3, form raw fraction.
module ramr_front import ramr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ramr_req_if.sink  req,
  ramr_raw_if.source raw
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  op_r;
  logic        an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [31:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic        p1_s_r, p2_s_r, pd_s_r;
  logic [63:0] p1_r, p2_r, pd_r;
  raw_frac_t   frac_r;

  // Take the sign at the operand width, return sign and magnitude.
  function automatic logic [32:0] take_op(input logic [31:0] raw_v);
    logic [OPERAND_WIDTH-1:0] v;
    logic [OPERAND_WIDTH-1:0] m;
    logic                     s;
    v = raw_v[OPERAND_WIDTH-1:0];
    s = v[OPERAND_WIDTH-1];
    m = s ? (~v + 1'b1) : v;
    return {s, {(32-OPERAND_WIDTH){1'b0}}, m};
  endfunction

  logic [32:0] an_t, ad_t, bn_t, bd_t;
  assign an_t = take_op(req.a_num);
  assign ad_t = take_op(req.a_den);
  assign bn_t = take_op(req.b_num);
  assign bd_t = take_op(req.b_den);

  assign req.ready = (state_r == S_IDLE);
  assign raw.valid = (state_r == S_OUT);
  assign raw.frac  = frac_r;

  // One 32x32 multiply per cycle.
  logic [31:0] mx, my;
  logic [63:0] mp;
  always_comb begin
    unique case (state_r)
      S_M1:    begin mx = an_m_r; my = (op_r == OP_ADD) ? bd_m_r : bn_m_r; end
      S_M2:    begin mx = bn_m_r; my = ad_m_r; end
      default: begin mx = ad_m_r; my = bd_m_r; end
    endcase
  end
  assign mp = {32'd0, mx} * {32'd0, my};

  // Signed add of the two cross products.
  logic        sum_s;
  logic [63:0] sum_m;
  always_comb begin
    if (p1_s_r == p2_s_r) begin
      sum_s = p1_s_r; sum_m = p1_r + p2_r;
    end else if (p1_r >= p2_r) begin
      sum_s = p1_s_r; sum_m = p1_r - p2_r;
    end else begin
      sum_s = p2_s_r; sum_m = p2_r - p1_r;
    end
    if (sum_m == 64'd0) sum_s = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req.valid) state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_OUT;
      S_OUT:  if (raw.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Capture operands, then advance products and build the raw fraction.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (req.valid) begin
        op_r <= req.req_type;
        {an_s_r, an_m_r} <= an_t;
        {ad_s_r, ad_m_r} <= ad_t;
        {bn_s_r, bn_m_r} <= bn_t;
        {bd_s_r, bd_m_r} <= bd_t;
      end
      S_M1: begin
        p1_r   <= mp;
        p1_s_r <= (an_s_r != ((op_r == OP_ADD) ? bd_s_r : bn_s_r)) && (mp != 64'd0);
      end
      S_M2: begin
        p2_r   <= mp;
        p2_s_r <= (bn_s_r != ad_s_r) && (mp != 64'd0);
      end
      S_M3: begin
        pd_r   <= mp;
        pd_s_r <= (ad_s_r != bd_s_r) && (mp != 64'd0);
      end
      S_SUM: begin
        unique case (op_r)
          OP_ADD: begin
            frac_r.num_neg <= sum_s;  frac_r.num_mag <= sum_m;
            frac_r.den_neg <= pd_s_r; frac_r.den_mag <= pd_r;
          end
          OP_MUL: begin
            frac_r.num_neg <= p1_s_r; frac_r.num_mag <= p1_r;
            frac_r.den_neg <= pd_s_r; frac_r.den_mag <= pd_r;
          end
          default: begin
            frac_r.num_neg <= an_s_r; frac_r.num_mag <= {32'd0, an_m_r};
            frac_r.den_neg <= ad_s_r; frac_r.den_mag <= {32'd0, ad_m_r};
          end
        endcase
        frac_r.zero_den <= ((op_r == OP_ADD) || (op_r == OP_MUL)) ?
                           (pd_r == 64'd0) : (ad_m_r == 32'd0);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ramr_queue.sv =====
// Two-entry queue between the front end and the reduction engine.
module ramr_queue import ramr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ramr_raw_if.sink   enq,
  ramr_raw_if.source deq
);

  raw_frac_t   mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign enq.ready = (cnt_r != 2'd2);
  assign deq.valid = (cnt_r != 2'd0);
  assign deq.frac  = mem_r[rp_r];
  assign push = enq.valid && enq.ready;
  assign pop  = deq.valid && deq.ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= enq.frac;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/ramr_reduce.sv =====
// Reduction engine: Euclidean GCD and divisions with a shared restoring divider.
module ramr_reduce import ramr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ramr_raw_if.sink   raw,
  ramr_res_if.source res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic        num_neg_r, den_neg_r, zero_r;
  logic [63:0] nm_r, dm_r, x_r, y_r, nq_r, dq_r;
  // Divider: dividend, divisor, quotient, remainder, step count.
  logic [63:0] dvd_r, dvs_r, quo_r, rem_r;
  logic [6:0]  cnt_r;
  logic        dbusy_r;
  logic [63:0] out_num_r;
  logic [62:0] out_den_r;
  logic        out_st_r;

  assign raw.ready   = (state_r == S_IDLE);
  assign res.valid   = (state_r == S_OUT);
  assign res.res_num = out_num_r;
  assign res.res_den = out_den_r;
  assign res.status  = out_st_r;

  // One restoring step per cycle.
  logic [64:0] rsh;
  logic [64:0] rdiff;
  assign rsh   = {rem_r, dvd_r[63]};
  assign rdiff = rsh - {1'b0, dvs_r};
  logic        ddone;
  assign ddone = dbusy_r && (cnt_r == 7'd64);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (raw.valid) state_nxt = raw.frac.zero_den ? S_DONE : S_GCD;
      S_GCD:  if (!dbusy_r && y_r == 64'd0) state_nxt = S_DIVN;
      S_DIVN: if (ddone) state_nxt = S_DIVD;
      S_DIVD: if (ddone) state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (res.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dbusy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Start the divider whenever a division is pending.
      if (dbusy_r) begin
        if (ddone) dbusy_r <= 1'b0;
      end else if ((state_r == S_GCD && y_r != 64'd0) ||
                   (state_r == S_DIVN) || (state_r == S_DIVD)) begin
        dbusy_r <= 1'b1;
      end
    end
  end

  // Datapath: load, step the divider, consume its results.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && raw.valid) begin
      num_neg_r <= raw.frac.num_neg;
      den_neg_r <= raw.frac.den_neg;
      zero_r    <= raw.frac.zero_den;
      nm_r      <= raw.frac.num_mag;
      dm_r      <= raw.frac.den_mag;
      x_r       <= raw.frac.num_mag;
      y_r       <= raw.frac.den_mag;
    end
    if (dbusy_r) begin
      if (!ddone) begin
        dvd_r <= {dvd_r[62:0], 1'b0};
        if (!rdiff[64]) begin
          rem_r <= rdiff[63:0]; quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh[63:0];   quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
      end else begin
        unique case (state_r)
          S_GCD: begin x_r <= y_r; y_r <= rem_r; end
          S_DIVN: nq_r <= quo_r;
          default: dq_r <= quo_r;
        endcase
      end
    end else if ((state_r == S_GCD && y_r != 64'd0) || state_r == S_DIVN ||
                 state_r == S_DIVD) begin
      cnt_r <= 7'd0;
      rem_r <= 64'd0;
      quo_r <= 64'd0;
      unique case (state_r)
        S_GCD:   begin dvd_r <= x_r;  dvs_r <= y_r; end
        S_DIVN:  begin dvd_r <= nm_r; dvs_r <= x_r; end
        default: begin dvd_r <= dm_r; dvs_r <= x_r; end
      endcase
    end
    // Apply sign and saturate.
    if (state_r == S_DONE) begin
      if (zero_r) begin
        out_num_r <= 64'd0; out_den_r <= 63'd0; out_st_r <= 1'b1;
      end else begin
        if ((num_neg_r != den_neg_r) && nq_r != 64'd0) out_num_r <= 64'd0 - nq_r;
        else if (nq_r[63]) out_num_r <= {1'b0, {63{1'b1}}};
        else out_num_r <= nq_r;
        out_den_r <= dq_r[62:0];
        out_st_r  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rational_add_multiply_reduce.sv =====
// Top level: front end, queue and reduction engine of the rational arithmetic unit.
// Path: the front end steps through its multiply states M1, M2 and M3, then SUM
// and OUT; the queue registers the raw fraction; the reduction engine then runs
// one divider pass per Euclid step, the last remainder test, the two final
// divisions and the output stage. A zero denominator skips the reduction.
// Throughput: one request per reduction time, set by the single shared bit-serial
// divider, while results are taken. Synchronous active-low reset clears control.
module rational_add_multiply_reduce import ramr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ramr_req_if.sink  in_req,
  ramr_res_if.source out_res
);

  ramr_raw_if f2q ();
  ramr_raw_if q2r ();

  ramr_front u_front (.clk(clk), .rst_n(rst_n), .req(in_req), .raw(f2q));
  ramr_queue u_queue (.clk(clk), .rst_n(rst_n), .enq(f2q), .deq(q2r));
  ramr_reduce u_reduce (.clk(clk), .rst_n(rst_n), .raw(q2r), .res(out_res));

endmodule

// ===== rtl/ramr_checker.sv =====
// Checker: port-level properties of the rational arithmetic unit, bound to the top.
module ramr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_num,
  input logic [62:0] out_den,
  input logic        out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_num))
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_num == 64'd0 && out_den == 63'd0)
    else $error("error result not 0/0");

  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_den != 63'd0)
    else $error("ok result with zero denominator");

endmodule

bind rational_add_multiply_reduce ramr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_num(out_res.res_num), .out_den(out_res.res_den), .out_status(out_res.status)
);

// ===== verif/tb_top.sv =====
// Testbench: directed and random requests checked against an internal fraction reducer.
import ramr_pkg::*;

typedef struct {
  logic [63:0] num;
  logic [62:0] den;
  logic        status;
} frac_res_t;

// Holds expected reduced fractions in request order and checks each result.
class frac_scoreboard;
  frac_res_t   expected_q[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned op_seen[4];
  int unsigned zero_den_seen;

  // Split an operand into sign and magnitude at the operand width.
  function automatic void split(input logic [31:0] raw, output bit neg,
                                output logic [63:0] mag);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
    v = {32'd0, raw} & mask;
    neg = v[OPERAND_WIDTH-1];
    mag = neg ? ((~v + 64'd1) & mask) : v;
  endfunction

  function automatic void mul(input bit xn, input logic [63:0] xm, input bit yn,
                              input logic [63:0] ym, output bit rn,
                              output logic [63:0] rm);
    rm = xm * ym;
    rn = (xn != yn) && (rm != 0);
  endfunction

  function automatic logic [63:0] gcd(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Work out the reduced fraction for one accepted request.
  function void note_request(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
    bit          an_n, ad_n, bn_n, bd_n, p_n, q_n, num_n, den_n, neg;
    logic [63:0] an_m, ad_m, bn_m, bd_m, p_m, q_m, num_m, den_m, g, nm, dm;
    frac_res_t   r;
    split(an, an_n, an_m);
    split(ad, ad_n, ad_m);
    split(bn, bn_n, bn_m);
    split(bd, bd_n, bd_m);
    op_seen[op]++;
    if (op == OP_ADD) begin
      mul(an_n, an_m, bd_n, bd_m, p_n, p_m);
      mul(bn_n, bn_m, ad_n, ad_m, q_n, q_m);
      if (p_n == q_n) begin
        num_n = p_n; num_m = p_m + q_m;
      end else if (p_m >= q_m) begin
        num_n = p_n; num_m = p_m - q_m;
      end else begin
        num_n = q_n; num_m = q_m - p_m;
      end
      if (num_m == 0) num_n = 0;
      mul(ad_n, ad_m, bd_n, bd_m, den_n, den_m);
    end else if (op == OP_MUL) begin
      mul(an_n, an_m, bn_n, bn_m, num_n, num_m);
      mul(ad_n, ad_m, bd_n, bd_m, den_n, den_m);
    end else begin
      num_n = an_n; num_m = an_m;
      den_n = ad_n; den_m = ad_m;
    end
    if (den_m == 0) begin
      r.num = '0; r.den = '0; r.status = 1'b1;
      zero_den_seen++;
    end else begin
      g = gcd(num_m, den_m);
      nm = num_m / g;
      dm = den_m / g;
      neg = (num_n != den_n) && (nm != 0);
      if (neg) r.num = 64'd0 - nm;
      else r.num = (nm > 64'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : nm;
      r.den = dm[62:0];
      r.status = 1'b0;
    end
    expected_q = {expected_q, r};
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(logic [63:0] num, logic [62:0] den, logic status);
    frac_res_t e;
    checked++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result %0d/%0d status %0b",
                                 $signed(num), den, status);
      return;
    end
    e = expected_q.pop_front();
    if (num !== e.num || den !== e.den || status !== e.status) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result %0d: expected %0d/%0d st %0b, got %0d/%0d st %0b",
                 checked, $signed(e.num), e.den, e.status, $signed(num), den, status);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     N_RANDOM = 1330;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  bit   quiet;
  longint unsigned cycles = 0;
  int   stall_left;

  ramr_req_if req_ch ();
  ramr_res_if res_ch ();

  frac_scoreboard sb;

  rational_add_multiply_reduce dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_res (res_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d results outstanding", sb.pending());
      $display("rational_add_multiply_reduce regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, none during a quiet stretch.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Stall the result side at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.res_num, res_ch.res_den, res_ch.status);
  end

  // Present one request and hold it until accepted.
  task automatic send_request(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.a_num    <= an;
    req_ch.a_den    <= ad;
    req_ch.b_num    <= bn;
    req_ch.b_den    <= bd;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, an, ad, bn, bd);
  endtask

  // Operand mix: full range, small values that reduce, extremes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(0, 120) - 60;
      6:       return $urandom_range(0, 200000) - 100000;
      7:       return ($urandom_range(0, 40) - 20) * ($urandom_range(1, 5000));
      8: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return ($urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff) << $urandom_range(0, 30);
    endcase
  endfunction

  initial begin
    logic [31:0] ext [6];
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = OP_NORM;
    req_ch.a_num = '0;
    req_ch.a_den = '0;
    req_ch.b_num = '0;
    req_ch.b_den = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every operation, zero denominators and numerators.
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0001};
    send_request(OP_NORM, 32'd6, 32'hffff_fff7, 32'd0, 32'd0);
    send_request(OP_NORM, 32'd0, 32'd5, 32'd0, 32'd0);
    send_request(OP_NORM, 32'd3, 32'd0, 32'd0, 32'd0);
    send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
    send_request(OP_MUL, 32'd1, 32'd0, 32'd1, 32'd3);
    send_request(OP_ADD, 32'd1, 32'd2, 32'hffff_ffff, 32'd2);
    send_request(OP_ADD, 32'd1, 32'd6, 32'd1, 32'd3);
    send_request(OP_MUL, 32'hffff_fffe, 32'd3, 32'd9, 32'hfffffffc);
    send_request(OP_SPARE, 32'd10, 32'hffff_fff1, 32'd7, 32'd7);
    for (int i = 0; i < 6; i++) begin
      send_request(OP_NORM, ext[i], ext[(i + 1) % 6], ext[i], ext[i]);
      send_request(OP_ADD, ext[i], ext[i], ext[(i + 4) % 6], ext[(i + 5) % 6]);
    end
    send_request(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001);
    send_request(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

    // Random: hold off once mid-run until every result is back.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (i == N_RANDOM / 2) begin
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_request(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
    end
    req_ch.valid <= 1'b0;

    // Drain and let the engine settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d normalize, %0d add, %0d multiply, %0d unused-code requests;",
             sb.op_seen[OP_NORM], sb.op_seen[OP_ADD], sb.op_seen[OP_MUL],
             sb.op_seen[OP_SPARE]);
    $display("%0d results checked, %0d with zero denominator, %0d mismatches.",
             sb.checked, sb.zero_den_seen, sb.errors);
    if (sb.errors == 0)
      $display("rational_add_multiply_reduce regression: pass");
    else
      $display("rational_add_multiply_reduce regression: fail");
    $finish;
  end
endmodule
